// ===== rtl/sbaf_pkg.sv =====
// Shared types and constants for the sonar/barometer altitude fusion block.
// No dependencies; imported by the serial arithmetic units and the top level.
`timescale 1ns / 1ps
`default_nettype none
package sbaf_pkg;

    localparam int MW      = 64;   // working width of the arithmetic datapath
    localparam int MUL_BW  = 25;   // multiplier bits, one per cycle
    localparam int DIV_DW  = 50;   // dividend magnitude bits, one per cycle
    localparam int DIV_RW  = 17;   // divisor and remainder width

    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 25;

    localparam int IN_W    = 128;
    localparam int OUT_W   = 88;

    localparam logic [MUL_BW-1:0] GAIN_ONE  = 25'h100_0000;
    localparam logic [DIV_RW-1:0] TICKS     = 17'd100000;
    localparam logic signed [MW-1:0] SPEED_CAP = 64'sd8388607;
    localparam logic signed [MW-1:0] ALT_MAX   = 64'sd1073741823;
    localparam logic signed [MW-1:0] ALT_MIN   = -64'sd1073741824;
    localparam logic signed [MW-1:0] SLOPE_MAX = 64'sd2147483648;

    typedef enum logic [CFG_AW-1:0] {
        REG_SONAR_GAIN  = 3'd0,
        REG_BARO_GAIN   = 3'd1,
        REG_SPEED_GAIN  = 3'd2,
        REG_SONAR_LIMIT = 3'd3,
        REG_TILT_LIMIT  = 3'd4
    } reg_idx_t;

endpackage
`default_nettype wire

// ===== rtl/sbaf_mul.sv =====
// Bit-serial shift-add multiplier: signed wide operand times unsigned 25-bit operand.
// Depends on sbaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbaf_mul (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic signed [sbaf_pkg::MW-1:0]  op_a,
    input  wire logic [sbaf_pkg::MUL_BW-1:0]     op_b,
    output logic                                 busy,
    output logic                                 done,
    output logic signed [sbaf_pkg::MW-1:0]       product
);
    import sbaf_pkg::*;

    localparam int CW = $clog2(MUL_BW + 1);

    logic signed [MW-1:0] a_reg;
    logic signed [MW-1:0] acc_reg;
    logic [MUL_BW-1:0]    b_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(MUL_BW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/sbaf_div.sv =====
// Bit-serial restoring divider, signed dividend by unsigned 17-bit divisor,
// quotient truncated toward zero. Depends on sbaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbaf_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic signed [sbaf_pkg::MW-1:0]  dividend,
    input  wire logic [sbaf_pkg::DIV_RW-1:0]     divisor,
    output logic                                 busy,
    output logic                                 done,
    output logic signed [sbaf_pkg::MW-1:0]       quotient
);
    import sbaf_pkg::*;

    localparam int CW = $clog2(DIV_DW + 1);

    logic [DIV_DW-1:0] num_reg;
    logic [DIV_RW-1:0] rem_reg;
    logic [DIV_RW-1:0] dsr_reg;
    logic              neg_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic signed [MW-1:0] mag;
    logic [DIV_RW:0]      rem_sh;
    logic [DIV_RW:0]      trial;
    logic signed [MW-1:0] qx;

    assign mag    = dividend[MW-1] ? -dividend : dividend;
    assign rem_sh = {rem_reg, num_reg[DIV_DW-1]};
    assign trial  = rem_sh - {1'b0, dsr_reg};
    assign qx     = {{(MW-DIV_DW){1'b0}}, num_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[MW-1];
            num_reg <= mag[DIV_DW-1:0];
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[DIV_RW]) begin
                rem_reg <= trial[DIV_RW-1:0];
                num_reg <= {num_reg[DIV_DW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[DIV_RW-1:0];
                num_reg <= {num_reg[DIV_DW-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -qx : qx;

endmodule
`default_nettype wire

// ===== rtl/sonar_baro_altitude_fusion_top.sv =====
// Sonar/barometer altitude fusion: complementary filter for altitude and vertical speed.
// Depends on sbaf_pkg, sbaf_mul and sbaf_div.
//
// One sample is taken at a time; s_tready is high only while the block is idle. A sample
// goes through mode decision and level shift; when the speed is updated it then takes
// four products, two quotients and a rounding step for the speed, and in every case
// three products, one quotient and a rounding step for the altitude, then the output
// step and the return to idle. The speed is not updated on a zero interval or, in sonar
// mode, an invalid previous sonar reading. Products come from the bit-serial multiplier
// and quotients from the bit-serial divider. The result waits in an output register, so
// a new sample is taken while it is still pending; a later result holds until that one is
// taken. Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata; the user must
// write it only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module sonar_baro_altitude_fusion_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [sbaf_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [sbaf_pkg::CFG_DW-1:0]   cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // sonar_alt, baro_alt, accel_z, pitch_deg, roll_deg, dt_ticks
    input  wire logic [sbaf_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // altitude_est, vertical_speed, level_shift
    output logic [sbaf_pkg::OUT_W-1:0]         m_tdata,
    // use_baro
    output logic                               m_tuser
);
    import sbaf_pkg::*;

    localparam logic signed [MW-1:0] SPD_RAW   = MW'(100) <<< FRAC_BITS;
    localparam logic signed [MW-1:0] SPEED_LIM = (SPD_RAW < SPEED_CAP) ? SPD_RAW : SPEED_CAP;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'h0001,
        ST_MODE  = 16'h0002,
        ST_LEVEL = 16'h0004,
        ST_VMUL  = 16'h0008,
        ST_VDIV  = 16'h0010,
        ST_SMUL  = 16'h0020,
        ST_SDIV  = 16'h0040,
        ST_PMUL0 = 16'h0080,
        ST_PMUL1 = 16'h0100,
        ST_PFIN  = 16'h0200,
        ST_AMUL  = 16'h0400,
        ST_ADIV  = 16'h0800,
        ST_HMUL0 = 16'h1000,
        ST_HMUL1 = 16'h2000,
        ST_HFIN  = 16'h4000,
        ST_OUT   = 16'h8000
    } state_t;

    function automatic logic signed [MW-1:0] clamp(input logic signed [MW-1:0] v,
                                                   input logic signed [MW-1:0] lo,
                                                   input logic signed [MW-1:0] hi);
        logic signed [MW-1:0] r;
        begin
            r = v;
            if (v < lo) r = lo;
            else if (v > hi) r = hi;
            return r;
        end
    endfunction

    function automatic logic [MUL_BW-1:0] gain_of(input logic [MUL_BW-1:0] g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

    // truncating divide by 2^24
    function automatic logic signed [MW-1:0] unscale(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] b;
        begin
            b = v[MW-1] ? MW'(24'hFF_FFFF) : '0;
            return (v + b) >>> 24;
        end
    endfunction

    // configuration
    logic [24:0] sonar_gain_reg, baro_gain_reg, speed_gain_reg;
    logic [19:0] sonar_limit_reg;
    logic [15:0] tilt_limit_reg;

    // filter state
    logic signed [30:0] alt_reg;
    logic signed [23:0] speed_reg;
    logic signed [20:0] last_sonar_reg;
    logic signed [30:0] last_baro_reg;
    logic               mode_reg;

    // sample and work registers
    logic signed [20:0] sonar_reg;
    logic signed [30:0] baro_reg;
    logic signed [24:0] accel_reg;
    logic signed [16:0] pitch_reg, roll_reg;
    logic [15:0]        dt_reg;
    logic               baro_mode_reg;
    logic signed [30:0] shift_reg;
    logic               slope_ok_reg;
    logic signed [30:0] cur_reg, prev_reg;
    logic [MUL_BW-1:0]  g_alt_reg;
    logic signed [MW-1:0] tmp_reg, slope_reg, acc_reg;

    state_t state_reg, state_next;
    logic   run_reg;
    logic   m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic   m_tuser_reg;

    // unit interface
    logic                 mul_start, mul_busy, mul_done;
    logic signed [MW-1:0] mul_a, mul_p;
    logic [MUL_BW-1:0]    mul_b;
    logic                 div_start, div_busy, div_done;
    logic signed [MW-1:0] div_n, div_q;
    logic [DIV_RW-1:0]    div_d;

    logic in_acc;
    logic is_mul, is_div;
    logic out_load;

    // mode decision
    logic signed [21:0] son_x, last_x, lim_x;
    logic [16:0]        pitch_abs, roll_abs;
    logic               mode_next;
    logic               last_ok;
    logic signed [MW-1:0] diff_w, shift_w, lvl_w;
    logic signed [MW-1:0] spd_w, alt_w;
    logic [MUL_BW-1:0]  gs;

    assign in_acc = s_tvalid && s_tready;
    assign gs     = gain_of(speed_gain_reg);

    assign son_x     = {sonar_reg[20], sonar_reg};
    assign last_x    = {last_sonar_reg[20], last_sonar_reg};
    assign lim_x     = $signed({2'b00, sonar_limit_reg});
    assign pitch_abs = pitch_reg[16] ? 17'(-pitch_reg) : 17'(pitch_reg);
    assign roll_abs  = roll_reg[16] ? 17'(-roll_reg) : 17'(roll_reg);
    assign mode_next = !(son_x > 22'sd0 && son_x < lim_x &&
                         pitch_abs < {1'b0, tilt_limit_reg} &&
                         roll_abs < {1'b0, tilt_limit_reg});
    assign last_ok   = last_x > 22'sd0 && last_x < lim_x;
    assign diff_w    = mode_next ? MW'(last_sonar_reg) - MW'(baro_reg)
                                 : MW'(last_baro_reg) - MW'(sonar_reg);
    assign shift_w   = (mode_next != mode_reg) ? clamp(diff_w, ALT_MIN, ALT_MAX) : '0;
    assign lvl_w     = clamp(MW'(alt_reg) - MW'(shift_reg), ALT_MIN, ALT_MAX);
    assign spd_w     = clamp(unscale(acc_reg), -SPEED_LIM, SPEED_LIM);
    assign alt_w     = clamp(unscale(acc_reg), ALT_MIN, ALT_MAX);

    assign is_mul = state_reg == ST_VMUL || state_reg == ST_SMUL || state_reg == ST_PMUL0 ||
                    state_reg == ST_PMUL1 || state_reg == ST_AMUL || state_reg == ST_HMUL0 ||
                    state_reg == ST_HMUL1;
    assign is_div = state_reg == ST_VDIV || state_reg == ST_SDIV || state_reg == ST_ADIV;
    assign mul_start = is_mul && !run_reg;
    assign div_start = is_div && !run_reg;
    assign out_load  = state_reg == ST_OUT && (!m_tvalid_reg || m_tready);

    always_comb begin
        mul_a = MW'(accel_reg);
        mul_b = MUL_BW'(dt_reg);
        div_n = mul_p;
        div_d = TICKS;
        unique case (state_reg)
            ST_SMUL: begin
                mul_a = MW'(cur_reg) - MW'(prev_reg);
                mul_b = MUL_BW'(TICKS);
            end
            ST_SDIV:  div_d = DIV_RW'(dt_reg);
            ST_PMUL0: begin
                mul_a = tmp_reg;
                mul_b = GAIN_ONE - gs;
            end
            ST_PMUL1: begin
                mul_a = slope_reg;
                mul_b = gs;
            end
            ST_AMUL:  mul_a = MW'(speed_reg);
            ST_HMUL0: begin
                mul_a = tmp_reg;
                mul_b = GAIN_ONE - g_alt_reg;
            end
            ST_HMUL1: begin
                mul_a = MW'(cur_reg);
                mul_b = g_alt_reg;
            end
            default: ;
        endcase
    end

    sbaf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    sbaf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_MODE;
            ST_MODE:  state_next = ST_LEVEL;
            ST_LEVEL: state_next = slope_ok_reg ? ST_VMUL : ST_AMUL;
            ST_VMUL:  if (mul_done) state_next = ST_VDIV;
            ST_VDIV:  if (div_done) state_next = ST_SMUL;
            ST_SMUL:  if (mul_done) state_next = ST_SDIV;
            ST_SDIV:  if (div_done) state_next = ST_PMUL0;
            ST_PMUL0: if (mul_done) state_next = ST_PMUL1;
            ST_PMUL1: if (mul_done) state_next = ST_PFIN;
            ST_PFIN:  state_next = ST_AMUL;
            ST_AMUL:  if (mul_done) state_next = ST_ADIV;
            ST_ADIV:  if (div_done) state_next = ST_HMUL0;
            ST_HMUL0: if (mul_done) state_next = ST_HMUL1;
            ST_HMUL1: if (mul_done) state_next = ST_HFIN;
            ST_HFIN:  state_next = ST_OUT;
            ST_OUT:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control, configuration and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            run_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            sonar_gain_reg  <= 25'd33554;
            baro_gain_reg   <= 25'd8389;
            speed_gain_reg  <= 25'd8389;
            sonar_limit_reg <= 20'd131072;
            tilt_limit_reg  <= 16'd2560;
            alt_reg         <= '0;
            speed_reg       <= '0;
            last_sonar_reg  <= '0;
            last_baro_reg   <= '0;
            mode_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mul_start || div_start) run_reg <= 1'b1;
            else if (mul_done || div_done) run_reg <= 1'b0;

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_SONAR_GAIN:  sonar_gain_reg  <= cfg_wdata;
                    REG_BARO_GAIN:   baro_gain_reg   <= cfg_wdata;
                    REG_SPEED_GAIN:  speed_gain_reg  <= cfg_wdata;
                    REG_SONAR_LIMIT: sonar_limit_reg <= cfg_wdata[19:0];
                    REG_TILT_LIMIT:  tilt_limit_reg  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end

            if (state_reg == ST_LEVEL) alt_reg <= lvl_w[30:0];
            if (state_reg == ST_PFIN)
                speed_reg <= spd_w[23:0];
            if (state_reg == ST_HFIN) begin
                alt_reg        <= alt_w[30:0];
                last_sonar_reg <= sonar_reg;
                last_baro_reg  <= baro_reg;
                mode_reg       <= baro_mode_reg;
            end

            m_tvalid_reg <= out_load || (m_tvalid_reg && !m_tready);
        end
    end

    // sample and datapath
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            sonar_reg <= s_tdata[20:0];
            baro_reg  <= s_tdata[51:21];
            accel_reg <= s_tdata[76:52];
            pitch_reg <= s_tdata[93:77];
            roll_reg  <= s_tdata[110:94];
            dt_reg    <= s_tdata[126:111];
        end
        if (state_reg == ST_MODE) begin
            baro_mode_reg <= mode_next;
            shift_reg     <= shift_w[30:0];
            if (mode_next) begin
                cur_reg      <= baro_reg;
                prev_reg     <= last_baro_reg;
                slope_ok_reg <= dt_reg != '0;
                g_alt_reg    <= gain_of(baro_gain_reg);
            end else begin
                cur_reg      <= 31'(sonar_reg);
                prev_reg     <= 31'(last_sonar_reg);
                slope_ok_reg <= dt_reg != '0 && last_ok;
                g_alt_reg    <= gain_of(sonar_gain_reg);
            end
        end
        if (div_done && state_reg == ST_VDIV) tmp_reg <= MW'(speed_reg) + div_q;
        if (div_done && state_reg == ST_SDIV) slope_reg <= clamp(div_q, -SLOPE_MAX, SLOPE_MAX);
        if (div_done && state_reg == ST_ADIV) tmp_reg <= MW'(alt_reg) + div_q;
        if (mul_done && (state_reg == ST_PMUL0 || state_reg == ST_HMUL0)) acc_reg <= mul_p;
        if (mul_done && (state_reg == ST_PMUL1 || state_reg == ST_HMUL1))
            acc_reg <= acc_reg + mul_p;
        if (out_load) begin
            m_tdata_reg <= {2'b00, shift_reg, speed_reg, alt_reg};
            m_tuser_reg <= baro_mode_reg;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    a_idle_units_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !mul_busy && !div_busy && !run_reg)
        else $error("arithmetic unit busy while idle");

    a_speed_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(state_reg == ST_PFIN) |-> MW'(speed_reg) <= SPEED_LIM &&
                                        MW'(speed_reg) >= -SPEED_LIM)
        else $error("speed beyond limit");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for sonar_baro_altitude_fusion_top: directed and random samples
// checked against an in-bench fixed-point model of the altitude/speed filter.
// Depends on sbaf_pkg and the RTL top level only.
`timescale 1ns / 1ps
module tb;
    import sbaf_pkg::*;

    localparam int  N_RANDOM   = 1500;
    localparam int  N_PHASES   = 6;
    localparam int  DRAIN_CYC  = 400;
    localparam longint LIMIT   = 10000000;
    localparam longint G_ONE   = 64'sd16777216;
    localparam longint TPS     = 100000;
    localparam longint SPD_LIM = 6553600;

    typedef struct packed {
        logic [15:0]        dt;
        logic signed [16:0] roll;
        logic signed [16:0] pitch;
        logic signed [24:0] accel;
        logic signed [30:0] baro;
        logic signed [20:0] sonar;
    } sample_t;

    typedef struct packed {
        logic [30:0] alt;
        logic [23:0] speed;
        logic        use_baro;
        logic [30:0] shift;
    } fused_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0]   cfg_addr = '0;
    logic [CFG_DW-1:0]   cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;

    sonar_baro_altitude_fusion_top dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // filter model state
    longint alt_q, spd_q, last_son, last_bar;
    bit     mode_q;
    longint g_sonar, g_baro, g_speed, son_lim, tilt_lim;

    fused_t pending_fused[$];
    int     n_err, n_results, n_items, n_sonar_mode, n_switches;
    longint cyc;
    bit     long_hold_req;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint gclamp(longint g);
        return g > G_ONE ? G_ONE : g;
    endfunction

    function automatic longint mix(longint g, longint a, longint b);
        return ((G_ONE - g) * a + g * b) / G_ONE;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic fused_t fuse_sample(sample_t s);
        longint son, bar, acc, dt, shift, cur, prv, ga, v1, slope, a1;
        bit     baro_m, slope_ok;
        fused_t r;
        son = longint'(s.sonar);
        bar = longint'(s.baro);
        acc = longint'(s.accel);
        dt  = longint'(s.dt);
        shift = 0;
        baro_m = !(son > 0 && son < son_lim && mag(longint'(s.pitch)) < tilt_lim
                   && mag(longint'(s.roll)) < tilt_lim);
        if (baro_m != mode_q) begin
            shift = baro_m ? last_son - bar : last_bar - son;
            shift = clip(shift, ALT_MIN, ALT_MAX);
            alt_q = clip(alt_q - shift, ALT_MIN, ALT_MAX);
            n_switches++;
        end
        if (!baro_m) begin
            cur = son; prv = last_son; ga = gclamp(g_sonar);
            slope_ok = dt > 0 && last_son > 0 && last_son < son_lim;
            n_sonar_mode++;
        end else begin
            cur = bar; prv = last_bar; ga = gclamp(g_baro);
            slope_ok = dt > 0;
        end
        if (slope_ok) begin
            v1 = spd_q + (acc * dt) / TPS;
            slope = clip(((cur - prv) * TPS) / dt, -SLOPE_MAX, SLOPE_MAX);
            spd_q = clip(mix(gclamp(g_speed), v1, slope), -SPD_LIM, SPD_LIM);
        end
        a1 = alt_q + (spd_q * dt) / TPS;
        alt_q = clip(mix(ga, a1, cur), ALT_MIN, ALT_MAX);
        last_son = son;
        last_bar = bar;
        mode_q = baro_m;
        r.alt = alt_q[30:0];
        r.speed = spd_q[23:0];
        r.use_baro = baro_m;
        r.shift = shift[30:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0d] mismatch %s: got %0h want %0h", cyc, what, got, want);
        n_err++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SONAR_GAIN:  g_sonar  = longint'(val);
            REG_BARO_GAIN:   g_baro   = longint'(val);
            REG_SPEED_GAIN:  g_speed  = longint'(val);
            REG_SONAR_LIMIT: son_lim  = longint'(val[19:0]);
            REG_TILT_LIMIT:  tilt_lim = longint'(val[15:0]);
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75) return 0;
        if (p < 95) return $urandom_range(1, 5);
        return $urandom_range(20, 200);
    endfunction

    // drives one item; when use_typed is set the given result is expected instead
    task automatic send_sample(sample_t s, int gap, bit use_typed, fused_t typed);
        fused_t r;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(s);
        do @(posedge aclk); while (!s_tready);
        r = fuse_sample(s);
        pending_fused.push_back(use_typed ? typed : r);
        n_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_fused.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    function automatic longint rnd_range(longint lo, longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic sample_t rnd_sample();
        sample_t s;
        int p;
        p = $urandom_range(0, 99);
        if (p < 70 && son_lim > 1)
            s.sonar = 21'(rnd_range(1, son_lim - 1));
        else
            s.sonar = 21'(rnd_range(-65536, 655360));
        if ($urandom_range(0, 9) < 8)
            s.baro = 31'(clip(last_bar + rnd_range(-200000, 200000), -655360000, 655360000));
        else
            s.baro = 31'(rnd_range(-655360000, 655360000));
        s.accel = $urandom_range(0, 3) == 0 ? 25'(rnd_range(-10485760, 10485760))
                                            : 25'(rnd_range(-200000, 200000));
        if ($urandom_range(0, 9) < 7 && tilt_lim > 0) begin
            s.pitch = 17'(rnd_range(-(tilt_lim - 1), tilt_lim - 1));
            s.roll  = 17'(rnd_range(-(tilt_lim - 1), tilt_lim - 1));
        end else begin
            s.pitch = 17'(rnd_range(-46080, 46079));
            s.roll  = 17'(rnd_range(-46080, 46079));
        end
        p = $urandom_range(0, 99);
        if (p < 8)       s.dt = 16'd0;
        else if (p < 85) s.dt = 16'($urandom_range(1, 5000));
        else             s.dt = 16'($urandom_range(0, 65535));
        return s;
    endfunction

    // result checker
    always @(posedge aclk) begin
        fused_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.alt = m_tdata[30:0];
            got.speed = m_tdata[54:31];
            got.shift = m_tdata[85:55];
            got.use_baro = m_tuser;
            n_results++;
            if (pending_fused.size() == 0) begin
                $display("[%0d] result with nothing pending", cyc);
                n_err++;
            end else begin
                want = pending_fused.pop_front();
                if (got.alt != want.alt)
                    report_mismatch("altitude_est", longint'(got.alt), longint'(want.alt));
                if (got.speed != want.speed)
                    report_mismatch("vertical_speed", longint'(got.speed),
                                    longint'(want.speed));
                if (got.use_baro != want.use_baro)
                    report_mismatch("use_baro", longint'(got.use_baro),
                                    longint'(want.use_baro));
                if (got.shift != want.shift)
                    report_mismatch("level_shift", longint'(got.shift), longint'(want.shift));
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        static int hold = 0;
        int p;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold = 3000;
            m_tready <= 1'b0;
        end else if (hold > 0) begin
            hold--;
            m_tready <= 1'b0;
        end else begin
            p = $urandom_range(0, 99);
            if (p < 75) begin
                m_tready <= 1'b1;
            end else begin
                hold = p < 96 ? $urandom_range(1, 6) : $urandom_range(30, 600);
                m_tready <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc > LIMIT) begin
            $display("timeout after %0d cycles", cyc);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        longint tab [20][6];
        fused_t none, typed;
        sample_t s;
        int ph;
        cyc = 0; n_err = 0; n_results = 0; n_items = 0;
        n_sonar_mode = 0; n_switches = 0; long_hold_req = 1'b0;
        alt_q = 0; spd_q = 0; last_son = 0; last_bar = 0; mode_q = 1'b0;
        g_sonar = 33554; g_baro = 8389; g_speed = 8389; son_lim = 131072; tilt_lim = 2560;
        none = '0;
        // sonar, baro, accel, pitch, roll, dt
        tab = '{
            '{0, 0, 0, 0, 0, 0},
            '{65536, 0, 0, 0, 0, 1000},
            '{70000, 100, 65536, 100, -100, 1000},
            '{131071, 200, -65536, 2559, -2559, 1},
            '{131072, 300, 0, 0, 0, 100},
            '{65536, 655360000, 10485760, 0, 0, 65535},
            '{65536, -655360000, -10485760, 2560, 0, 65535},
            '{-65536, -655360000, 10485760, -46080, 46079, 65535},
            '{655360, 655360000, -10485760, 46079, -46080, 65535},
            '{100000, 655360000, 10485760, 0, 0, 65535},
            '{-1, -655360000, -10485760, 0, 0, 1},
            '{1, 655360000, 10485760, 0, -2560, 65535},
            '{1, 655360000, 10485760, 0, 0, 0},
            '{2, 655360000, 0, 0, 0, 1},
            '{0, -655360000, 0, 0, 0, 1},
            '{50000, 0, 0, -2559, 2559, 500},
            '{60000, 0, 0, 0, 0, 0},
            '{-65536, 12345, -1, 0, 0, 65535},
            '{131071, 0, 1, 0, 0, 65535},
            '{1000, 1000, 0, 0, 0, 10}
        };
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < 20; i++) begin
            s.sonar = 21'(tab[i][0]); s.baro = 31'(tab[i][1]); s.accel = 25'(tab[i][2]);
            s.pitch = 17'(tab[i][3]); s.roll = 17'(tab[i][4]); s.dt = 16'(tab[i][5]);
            typed = none;
            if (i == 0) begin
                typed.use_baro = 1'b1;
            end else if (i == 1) begin
                typed.alt = 31'd65536;
                typed.shift = 31'h7FFF_0000;
            end
            send_sample(s, pick_gap(), i < 2, typed);
        end
        drain_results();

        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(REG_SONAR_GAIN, 25'h1FF_FFFF);
                    write_reg(REG_BARO_GAIN, 25'h100_0000);
                    write_reg(REG_SPEED_GAIN, 25'h100_0000);
                    write_reg(REG_SONAR_LIMIT, 25'd655360);
                    write_reg(REG_TILT_LIMIT, 25'd46080);
                end
                2: begin
                    write_reg(REG_SONAR_GAIN, 25'd0);
                    write_reg(REG_BARO_GAIN, 25'd0);
                    write_reg(REG_SPEED_GAIN, 25'd0);
                    write_reg(REG_SONAR_LIMIT, 25'd0);
                    write_reg(REG_TILT_LIMIT, 25'd0);
                end
                3: begin
                    write_reg(REG_SONAR_GAIN, 25'h1FF_FFFF);
                    write_reg(REG_BARO_GAIN, 25'h1FF_FFFF);
                    write_reg(REG_SPEED_GAIN, 25'h1FF_FFFF);
                    write_reg(REG_SONAR_LIMIT, 25'hF_FFFF);
                    write_reg(REG_TILT_LIMIT, 25'hFFFF);
                end
                default: begin
                    write_reg(REG_SONAR_GAIN, CFG_DW'($urandom_range(0, 16777216)));
                    write_reg(REG_BARO_GAIN, CFG_DW'($urandom_range(0, 16777216)));
                    write_reg(REG_SPEED_GAIN, CFG_DW'($urandom_range(0, 16777216)));
                    write_reg(REG_SONAR_LIMIT, CFG_DW'($urandom_range(1000, 655360)));
                    write_reg(REG_TILT_LIMIT, CFG_DW'($urandom_range(100, 46080)));
                end
            endcase
            for (int k = 0; k < N_RANDOM / N_PHASES; k++) begin
                if (ph == 0 && k == 20) long_hold_req = 1'b1;
                send_sample(rnd_sample(), ($urandom_range(0, 3) == 0) ? 0 : pick_gap(),
                            1'b0, none);
            end
            drain_results();
        end

        $display("%0d samples, %0d results, %0d in sonar mode, %0d mode changes",
                 n_items, n_results, n_sonar_mode, n_switches);
        $display("%0d configuration phases including zero and full-scale gains", N_PHASES);
        if (n_err == 0 && pending_fused.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/sbaf_pkg.sv
rtl/sbaf_mul.sv
rtl/sbaf_div.sv
rtl/sonar_baro_altitude_fusion_top.sv
dv/tb.sv
